// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the RTL of the dispatcher
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define LWQD_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("lwqd: %s", "same-cycle check failed");

// antecedent implies consequent in the next cycle
`define LWQD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lwqd: %s", "next-cycle check failed");

`endif

// ===== rtl/core/lwqd_pkg.sv =====
// Types and constants of the least-work queue dispatcher
package lwqd_pkg;

  localparam logic [1:0] ACT_OPEN   = 2'd0;
  localparam logic [1:0] ACT_CLOSE  = 2'd1;
  localparam logic [1:0] ACT_ARRIVE = 2'd2;
  localparam logic [1:0] ACT_REPORT = 2'd3;

  localparam logic CFG_SCAN = 1'b0;
  localparam logic CFG_PAY  = 1'b1;

  localparam logic [7:0]  SCAN_RESET = 8'd5;
  localparam logic [7:0]  PAY_RESET  = 8'd5;
  localparam logic [23:0] PEND_MAX   = 24'hFFFFFF;

  typedef struct packed {
    logic [1:0]  action;
    logic [2:0]  queue_id;
    logic [15:0] gap_time;
    logic [9:0]  job_items;
  } in_t;

  typedef struct packed {
    logic [2:0]  target_queue;
    logic        queue_open;
    logic [6:0]  job_count;
    logic [23:0] pending_time;
    logic        last;
  } out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_OPEN,
    ST_CLOSE,
    ST_CLOSE_RD,
    ST_CLOSE_DATA,
    ST_DRAIN_SUB,
    ST_DRAIN_STEP,
    ST_POP_RD,
    ST_POP_WR,
    ST_SEARCH,
    ST_PLACE,
    ST_EMIT
  } state_e;

endpackage

// ===== rtl/core/lwqd_ram.sv =====
// Generic single-write, single-read RAM with registered read data
module lwqd_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/lwqd_cost.sv =====
// Job cost unit: item count times per-item time plus the fixed job overhead, registered
module lwqd_cost import lwqd_pkg::*; (
  input  logic        clk_i,
  input  logic [9:0]  items_i,
  input  logic [7:0]  scan_i,
  input  logic [7:0]  pay_i,
  output logic [17:0] cost_o
);

  logic [17:0] cost_d, cost_q;

  assign cost_d = 18'(items_i) * 18'(scan_i) + 18'(pay_i);

  always_ff @(posedge clk_i) begin
    cost_q <= cost_d;
  end

  assign cost_o = cost_q;

endmodule

// ===== rtl/core/least_work_queue_dispatcher_top.sv =====
// Top level of the least-work queue dispatcher: sequencer and per-queue state
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+--------------------
//  in      | input     | in_valid_i/in_stall_o | in_data_i  (in_t)
//  out     | output    | out_valid_o/out_stall_i| out_data_o (out_t)
//  cfg     | input     | cfg_we_i              | cfg_index_i, cfg_data_i
//
// One event at a time. Open: one state to set up the queue, then emit; report:
// one emit per queue. Arrival: per queue a pending subtract and drain steps,
// plus a job store read and cost multiply per popped head job, then a search over all queues, place, emit.
// Close: per relocated job a store read, a search over all queues, place, emit.
// Reset clears all queue state at once; the job store needs no clearing.
// A stalled result holds in the output register; the next event is taken
// meanwhile and waits for that register only when it has a result ready.
`include "assert_macros.svh"
module least_work_queue_dispatcher_top import lwqd_pkg::*; #(
  parameter int MAX_QUEUES  = 8,
  parameter int QUEUE_DEPTH = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  in_t        in_data_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output out_t       out_data_o,
  input  logic       cfg_we_i,
  input  logic       cfg_index_i,
  input  logic [7:0] cfg_data_i
);

  localparam int QW = (MAX_QUEUES > 1) ? $clog2(MAX_QUEUES) : 1;
  localparam int DW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int AW = $clog2(MAX_QUEUES * QUEUE_DEPTH);
  localparam logic [QW-1:0] LAST_Q = QW'(MAX_QUEUES - 1);

  typedef struct packed {
    logic          open;
    logic [23:0]   pend;
    logic [17:0]   hl;
    logic [DW-1:0] head;
    logic [CW-1:0] cnt;
  } qrec_t;

  function automatic logic [DW-1:0] wrap_add(logic [DW-1:0] a, logic [CW-1:0] b);
    logic [CW:0] s;
    s = (CW+1)'(a) + (CW+1)'(b);
    if (s >= (CW+1)'(QUEUE_DEPTH)) s = s - (CW+1)'(QUEUE_DEPTH);
    return s[DW-1:0];
  endfunction

  function automatic logic [AW-1:0] slot_addr(logic [QW-1:0] q, logic [DW-1:0] s);
    return AW'(q) * AW'(QUEUE_DEPTH) + AW'(s);
  endfunction

  state_e        state_q, state_d;
  qrec_t         qs_q [MAX_QUEUES];
  qrec_t         rec, rec_d;
  logic [QW-1:0] cur_q, cur_d, best_q, best_d;
  logic [23:0]   best_pend_q, best_pend_d;
  logic          found_q, found_d;
  logic [15:0]   gap_q, gap_d, gap_left_q, gap_left_d;
  logic [9:0]    items_q, items_d;
  logic [2:0]    qid_q, qid_d;
  logic          qid_ok_q, qid_ok_d;
  logic [1:0]    action_q, action_d;
  logic [DW-1:0] chead_q, chead_d;
  logic [CW-1:0] ccnt_q, ccnt_d, k_q, k_d;
  logic [2:0]    tgt_q, tgt_d;
  logic          zero_q, zero_d, elast_q, elast_d;
  logic          out_valid_q, out_valid_d;
  out_t          out_q, out_d;
  logic [7:0]    scan_q, pay_q;

  logic          in_xfer, out_free, is_last, elig, take, close_last;
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [9:0]    ram_rdata, cost_items;
  logic [17:0]   cost;
  logic [24:0]   sum;
  logic [DW-1:0] pop_head;
  logic [CW-1:0] pop_cnt;

  assign rec        = qs_q[cur_q];
  assign in_xfer    = in_valid_i && (state_q == ST_IDLE);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign is_last    = (cur_q == LAST_Q);
  assign elig       = rec.open && (rec.cnt < CW'(QUEUE_DEPTH));
  assign take       = elig && (!found_q || (rec.pend < best_pend_q));
  assign close_last = ((CW+1)'(k_q) + (CW+1)'(1)) >= (CW+1)'(ccnt_q);
  assign sum        = 25'(rec.pend) + 25'(cost);
  assign pop_head   = wrap_add(rec.head, CW'(1));
  assign pop_cnt    = rec.cnt - CW'(1);
  assign cost_items = (state_q == ST_POP_RD) ? ram_rdata : items_q;

  assign ram_we    = (state_q == ST_PLACE);
  assign ram_waddr = slot_addr(cur_q, wrap_add(rec.head, rec.cnt));
  assign ram_raddr = (state_q == ST_CLOSE_RD) ? slot_addr(QW'(qid_q), wrap_add(chead_q, k_q))
                                              : slot_addr(cur_q, pop_head);

  lwqd_ram #(.WIDTH(10), .DEPTH(MAX_QUEUES * QUEUE_DEPTH)) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (items_q),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  lwqd_cost u_cost (
    .clk_i   (clk_i),
    .items_i (cost_items),
    .scan_i  (scan_q),
    .pay_i   (pay_q),
    .cost_o  (cost)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          unique case (in_data_i.action)
            ACT_OPEN:   state_d = ST_OPEN;
            ACT_CLOSE:  state_d = ST_CLOSE;
            ACT_ARRIVE: state_d = (in_data_i.gap_time != '0) ? ST_DRAIN_SUB : ST_SEARCH;
            default:    state_d = ST_EMIT;
          endcase
        end
      end
      ST_OPEN:       state_d = ST_EMIT;
      ST_CLOSE:      state_d = (qid_ok_q && rec.cnt > CW'(1)) ? ST_CLOSE_RD : ST_EMIT;
      ST_CLOSE_RD:   state_d = ST_CLOSE_DATA;
      ST_CLOSE_DATA: state_d = ST_SEARCH;
      ST_DRAIN_SUB: begin
        if (rec.open && rec.cnt != '0) state_d = ST_DRAIN_STEP;
        else if (is_last)              state_d = ST_SEARCH;
      end
      ST_DRAIN_STEP: begin
        if (gap_left_q != '0 && rec.cnt != '0) begin
          if (rec.hl > 18'(gap_left_q)) state_d = is_last ? ST_SEARCH : ST_DRAIN_SUB;
          else if (pop_cnt != '0)       state_d = ST_POP_RD;
        end else begin
          state_d = is_last ? ST_SEARCH : ST_DRAIN_SUB;
        end
      end
      ST_POP_RD:  state_d = ST_POP_WR;
      ST_POP_WR:  state_d = ST_DRAIN_STEP;
      ST_SEARCH: begin
        if (is_last) state_d = (found_q || take) ? ST_PLACE : ST_EMIT;
      end
      ST_PLACE:   state_d = ST_EMIT;
      ST_EMIT: begin
        if (out_free) begin
          if (elast_q)                      state_d = ST_IDLE;
          else if (action_q == ACT_CLOSE)   state_d = ST_CLOSE_RD;
        end
      end
      default:    state_d = ST_IDLE;
    endcase
  end

  // datapath next values
  always_comb begin
    rec_d       = rec;
    cur_d       = cur_q;
    best_d      = best_q;
    best_pend_d = best_pend_q;
    found_d     = found_q;
    gap_d       = gap_q;
    gap_left_d  = gap_left_q;
    items_d     = items_q;
    qid_d       = qid_q;
    qid_ok_d    = qid_ok_q;
    action_d    = action_q;
    chead_d     = chead_q;
    ccnt_d      = ccnt_q;
    k_d         = k_q;
    tgt_d       = tgt_q;
    zero_d      = zero_q;
    elast_d     = elast_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          action_d = in_data_i.action;
          qid_d    = in_data_i.queue_id;
          qid_ok_d = 32'(in_data_i.queue_id) < MAX_QUEUES;
          gap_d    = in_data_i.gap_time;
          items_d  = in_data_i.job_items;
          found_d  = 1'b0;
          tgt_d    = '0;
          zero_d   = 1'b0;
          elast_d  = 1'b0;
          if (in_data_i.action == ACT_OPEN || in_data_i.action == ACT_CLOSE) begin
            cur_d = QW'(in_data_i.queue_id);
          end else begin
            cur_d = '0;
          end
        end
      end
      ST_OPEN: begin
        if (qid_ok_q) rec_d = '{open: 1'b1, default: '0};
        tgt_d   = qid_q;
        zero_d  = !qid_ok_q;
        elast_d = 1'b1;
      end
      ST_CLOSE: begin
        chead_d = rec.head;
        ccnt_d  = qid_ok_q ? rec.cnt : '0;
        k_d     = CW'(1);
        if (qid_ok_q) rec_d = '0;
        tgt_d   = qid_q;
        zero_d  = !qid_ok_q;
        elast_d = 1'b1;
      end
      ST_CLOSE_DATA: begin
        items_d = ram_rdata;
        cur_d   = '0;
        found_d = 1'b0;
      end
      ST_DRAIN_SUB: begin
        if (rec.open && rec.cnt != '0) begin
          rec_d.pend = (rec.pend > 24'(gap_q)) ? rec.pend - 24'(gap_q) : '0;
          gap_left_d = gap_q;
        end else begin
          cur_d = is_last ? '0 : cur_q + QW'(1);
        end
      end
      ST_DRAIN_STEP: begin
        if (gap_left_q != '0 && rec.cnt != '0) begin
          if (rec.hl > 18'(gap_left_q)) begin
            rec_d.hl   = rec.hl - 18'(gap_left_q);
            gap_left_d = '0;
            cur_d      = is_last ? '0 : cur_q + QW'(1);
          end else begin
            gap_left_d = gap_left_q - 16'(rec.hl);
            rec_d.head = pop_head;
            rec_d.cnt  = pop_cnt;
            if (pop_cnt == '0) rec_d.hl = '0;
          end
        end else begin
          cur_d = is_last ? '0 : cur_q + QW'(1);
        end
      end
      ST_POP_WR: rec_d.hl = cost;
      ST_SEARCH: begin
        if (take) begin
          best_d      = cur_q;
          best_pend_d = rec.pend;
          found_d     = 1'b1;
        end
        if (is_last) begin
          elast_d = (action_q == ACT_ARRIVE) || close_last;
          if (found_q || take) begin
            cur_d = take ? cur_q : best_q;
          end else begin
            // dropped job: arrival names queue 0, relocation the closing queue
            zero_d = 1'b1;
            tgt_d  = (action_q == ACT_ARRIVE) ? 3'd0 : qid_q;
          end
        end else begin
          cur_d = cur_q + QW'(1);
        end
      end
      ST_PLACE: begin
        if (rec.cnt == '0) rec_d.hl = cost;
        rec_d.cnt  = rec.cnt + CW'(1);
        rec_d.pend = sum[24] ? PEND_MAX : sum[23:0];
        tgt_d      = 3'(cur_q);
        zero_d     = 1'b0;
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_d          = 1'b1;
          out_d.target_queue   = tgt_q;
          out_d.queue_open     = !zero_q && rec.open;
          out_d.job_count      = zero_q ? '0 : 7'(rec.cnt);
          out_d.pending_time   = zero_q ? '0 : rec.pend;
          out_d.last           = elast_q;
          if (!elast_q) begin
            if (action_q == ACT_REPORT) begin
              cur_d   = cur_q + QW'(1);
              tgt_d   = 3'(cur_q + QW'(1));
              elast_d = ((cur_q + QW'(1)) == LAST_Q);
            end else begin
              k_d = k_q + CW'(1);
            end
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      cur_q       <= '0;
      found_q     <= 1'b0;
      elast_q     <= 1'b0;
      k_q         <= '0;
      ccnt_q      <= '0;
      action_q    <= ACT_OPEN;
      scan_q      <= SCAN_RESET;
      pay_q       <= PAY_RESET;
      for (int i = 0; i < MAX_QUEUES; i++) begin
        qs_q[i] <= '0;
      end
    end else begin
      state_q       <= state_d;
      out_valid_q   <= out_valid_d;
      cur_q         <= cur_d;
      found_q       <= found_d;
      elast_q       <= elast_d;
      k_q           <= k_d;
      ccnt_q        <= ccnt_d;
      action_q      <= action_d;
      qs_q[cur_q]   <= rec_d;
      if (cfg_we_i) begin
        if (cfg_index_i == CFG_SCAN) scan_q <= cfg_data_i;
        if (cfg_index_i == CFG_PAY)  pay_q  <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    best_q      <= best_d;
    best_pend_q <= best_pend_d;
    gap_q       <= gap_d;
    gap_left_q  <= gap_left_d;
    items_q     <= items_d;
    qid_q       <= qid_d;
    qid_ok_q    <= qid_ok_d;
    chead_q     <= chead_d;
    tgt_q       <= tgt_d;
    zero_q      <= zero_d;
    out_q       <= out_d;
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // chosen queue must still be eligible when the job is written
  `LWQD_ASSERT_SAME(a_place_elig, state_q == ST_PLACE, qs_q[cur_q].open && (qs_q[cur_q].cnt < CW'(QUEUE_DEPTH)))
  // a head reload only happens on a queue that still holds jobs
  `LWQD_ASSERT_SAME(a_pop_nonempty, state_q == ST_POP_WR, qs_q[cur_q].cnt != '0)
  // every accepted event leaves idle
  `LWQD_ASSERT_NEXT(a_busy_after_xfer, in_valid_i && !in_stall_o, state_q != ST_IDLE)

endmodule
